// ===== hw/rtl/usb_ep0_pkg.sv =====
package usb_ep0_pkg;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned ActW     = 3;
  localparam int unsigned StateW   = 3;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned LenW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned NumStr   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_BUS_RESET = 2'd0,
    CMD_SETUP     = 2'd1,
    CMD_IN_DONE   = 2'd2
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE  = 3'd0,
    ACT_DEV   = 3'd1,
    ACT_CFG   = 3'd2,
    ACT_STR   = 3'd3,
    ACT_ZLP   = 3'd4,
    ACT_STALL = 3'd5
  } action_e;

  typedef enum logic [StateW-1:0] {
    ST_DEFAULT      = 3'd0,
    ST_ADDR_PENDING = 3'd1,
    ST_ADDRESSED    = 3'd2,
    ST_CFG_FETCHED  = 3'd3,
    ST_CONFIGURED   = 3'd4
  } dev_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEV_LEN  = 3'd0,
    REG_CFG_LEN  = 3'd1,
    REG_STR_CNT  = 3'd2,
    REG_STR0_LEN = 3'd3,
    REG_STR1_LEN = 3'd4,
    REG_STR2_LEN = 3'd5,
    REG_STR3_LEN = 3'd6
  } cfg_reg_e;

  localparam logic [7:0] REQ_DEV_TO_HOST = 8'h80;
  localparam logic [7:0] REQ_HOST_TO_DEV = 8'h00;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] REQ_GET_DESC    = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;

  localparam logic [7:0] DESC_DEVICE = 8'h01;
  localparam logic [7:0] DESC_CONFIG = 8'h02;
  localparam logic [7:0] DESC_STRING = 8'h03;

  typedef struct packed {
    logic [LenW-1:0] request_length;
    logic [15:0]     request_value;
    logic [7:0]      request_code;
    logic [7:0]      request_type;
  } req_t;

  typedef struct packed {
    logic [1:0]       pad;
    dev_state_e       dev_state;
    logic [AddrW-1:0] device_address;
    logic             address_write;
    logic             enable_bulk_endpoint;
    logic [LenW-1:0]  transfer_length;
    logic [1:0]       descriptor_index;
  } rsp_t;

endpackage

// ===== hw/rtl/usb_ep0_standard_request_handler_unit.sv =====
// Channel  | Dir | tuser          | tdata (low bit up)
// s_axis   | in  | command[1:0]   | request_type, request_code, request_value, request_length
// m_axis   | out | action[2:0]    | descriptor_index, transfer_length, enable_bulk_endpoint,
//          |     |                | address_write, device_address, dev_state, 2'b0
// cfg      | in  | -              | cfg_idx_i selects register, cfg_data_i holds value
//
// Input register, then decode and state update into the result register. One event
// per cycle sustained while m_axis is ready.
// Device state and addresses update as the event leaves the input register.
// Stall on m_axis backs up through both registers to s_axis_tready.
// Reset clears state, addresses and valids and loads default descriptor lengths and string count.
module usb_ep0_standard_request_handler_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [usb_ep0_pkg::InDataW-1:0]     s_axis_tdata,  // type, code, value, length
  input  logic [usb_ep0_pkg::CmdW-1:0]        s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [usb_ep0_pkg::OutDataW-1:0]    m_axis_tdata,  // didx, len, bulk, awr, addr, state
  output logic [usb_ep0_pkg::ActW-1:0]        m_axis_tuser,  // action
  input  logic                                cfg_we_i,
  input  logic [usb_ep0_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [usb_ep0_pkg::CfgDataW-1:0]    cfg_data_i
);
  import usb_ep0_pkg::*;

  logic [7:0]      dev_len_q;
  logic [LenW-1:0] cfg_len_q;
  logic [2:0]      str_cnt_q;
  logic [7:0]      str_len_q [NumStr];

  logic            in_vld_q;
  req_t            req_q;
  logic [CmdW-1:0] cmd_q;

  logic            out_vld_q;
  rsp_t            rsp_q, rsp_d;
  action_e         act_q, act_d;

  dev_state_e       state_q, state_d;
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;
  logic [AddrW-1:0] appl_addr_q, appl_addr_d;

  logic out_adv, in_adv;

  assign out_adv       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_len_q    <= 8'd18;
      cfg_len_q    <= 16'd32;
      str_cnt_q    <= 3'd4;
      str_len_q[0] <= 8'd4;
      str_len_q[1] <= 8'd10;
      str_len_q[2] <= 8'd14;
      str_len_q[3] <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DEV_LEN:  dev_len_q    <= cfg_data_i[7:0];
        REG_CFG_LEN:  cfg_len_q    <= cfg_data_i;
        REG_STR_CNT:  str_cnt_q    <= cfg_data_i[2:0];
        REG_STR0_LEN: str_len_q[0] <= cfg_data_i[7:0];
        REG_STR1_LEN: str_len_q[1] <= cfg_data_i[7:0];
        REG_STR2_LEN: str_len_q[2] <= cfg_data_i[7:0];
        REG_STR3_LEN: str_len_q[3] <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      req_q <= req_t'(s_axis_tdata);
      cmd_q <= s_axis_tuser;
    end
  end

  // decode of the registered event
  logic       is_get_desc, is_set_addr, is_set_cfg;
  logic [7:0] dtype, sidx;
  logic [2:0] str_lim;
  logic       str_ok;
  logic [7:0] str_len;

  assign is_get_desc = (req_q.request_type == REQ_DEV_TO_HOST) &&
                       (req_q.request_code == REQ_GET_DESC);
  assign is_set_addr = (req_q.request_type == REQ_HOST_TO_DEV) &&
                       (req_q.request_code == REQ_SET_ADDRESS);
  assign is_set_cfg  = (req_q.request_type == REQ_HOST_TO_DEV) &&
                       (req_q.request_code == REQ_SET_CONFIG);
  assign dtype   = req_q.request_value[15:8];
  assign sidx    = req_q.request_value[7:0];
  assign str_lim = (str_cnt_q > 3'(NumStr)) ? 3'(NumStr) : str_cnt_q;
  assign str_ok  = sidx < {5'd0, str_lim};
  assign str_len = str_len_q[sidx[1:0]];

  // next state
  always_comb begin
    state_d     = state_q;
    pend_addr_d = pend_addr_q;
    appl_addr_d = appl_addr_q;
    case (cmd_e'(cmd_q))
      CMD_BUS_RESET: state_d = ST_DEFAULT;
      CMD_SETUP: begin
        if (!is_get_desc && is_set_addr) begin
          pend_addr_d = req_q.request_value[AddrW-1:0];
          state_d     = ST_ADDR_PENDING;
        end else if (!is_get_desc && is_set_cfg) begin
          state_d = ST_CONFIGURED;
        end
      end
      CMD_IN_DONE: begin
        if (state_q == ST_ADDR_PENDING) begin
          appl_addr_d = pend_addr_q;
          state_d     = ST_ADDRESSED;
        end else if (state_q == ST_ADDRESSED) begin
          state_d = ST_CFG_FETCHED;
        end
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    act_d = ACT_NONE;
    rsp_d = '0;
    case (cmd_e'(cmd_q))
      CMD_SETUP: begin
        if (is_get_desc) begin
          if (dtype == DESC_DEVICE) begin
            act_d                 = ACT_DEV;
            rsp_d.transfer_length = {8'd0, dev_len_q};
          end else if (dtype == DESC_CONFIG) begin
            act_d                 = ACT_CFG;
            rsp_d.transfer_length = (req_q.request_length < cfg_len_q) ?
                                    req_q.request_length : cfg_len_q;
          end else if (dtype == DESC_STRING && str_ok) begin
            act_d                  = ACT_STR;
            rsp_d.descriptor_index = sidx[1:0];
            rsp_d.transfer_length  = (req_q.request_length < {8'd0, str_len}) ?
                                     req_q.request_length : {8'd0, str_len};
          end else begin
            act_d = ACT_STALL;
          end
        end else if (is_set_addr) begin
          act_d = ACT_ZLP;
        end else if (is_set_cfg) begin
          act_d                      = ACT_ZLP;
          rsp_d.enable_bulk_endpoint = 1'b1;
        end else begin
          act_d = ACT_STALL;
        end
      end
      CMD_IN_DONE: rsp_d.address_write = (state_q == ST_ADDR_PENDING);
      default: ;
    endcase
    rsp_d.device_address = appl_addr_d;
    rsp_d.dev_state      = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DEFAULT;
      pend_addr_q <= '0;
      appl_addr_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_adv) begin
        state_q     <= state_d;
        pend_addr_q <= pend_addr_d;
        appl_addr_q <= appl_addr_d;
        out_vld_q   <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      rsp_q <= rsp_d;
      act_q <= act_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = rsp_q;
  assign m_axis_tuser  = act_q;

endmodule

// ===== hw/rtl/usb_ep0_checker.sv =====
module usb_ep0_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [usb_ep0_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [usb_ep0_pkg::ActW-1:0]     m_axis_tuser
);
  import usb_ep0_pkg::*;

  rsp_t rsp;
  assign rsp = rsp_t'(m_axis_tdata);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_awr_addressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rsp.address_write |->
      rsp.dev_state == ST_ADDRESSED && m_axis_tuser == ACT_NONE)
    else $error("address applied outside status completion");

  a_bulk_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rsp.enable_bulk_endpoint |->
      rsp.dev_state == ST_CONFIGURED && m_axis_tuser == ACT_ZLP)
    else $error("bulk enable without set configuration");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ACT_DEV && m_axis_tuser != ACT_CFG &&
      m_axis_tuser != ACT_STR |->
      rsp.transfer_length == '0 && rsp.descriptor_index == '0)
    else $error("length or index set without data stage");

  a_act_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= ACT_STALL && rsp.pad == '0)
    else $error("bad action code or padding");

endmodule

bind usb_ep0_standard_request_handler_unit usb_ep0_checker u_usb_ep0_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
